[rtl/kect_pkg.sv]
// ----------------------------------------------------------------------------
// kect_pkg: shared types and constants for the keyed ewma cost table
// entry layout, status codes and the shared averaging unit's opcodes
// ----------------------------------------------------------------------------
package kect_pkg;

  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned UsedW   = $clog2(Entries + 1);

  localparam logic [47:0] PriorReset = 48'd16000000;
  localparam logic [15:0] CntMax     = 16'hFFFF;

  localparam logic [2:0] StSkip   = 3'd0;
  localparam logic [2:0] StUpdate = 3'd1;
  localparam logic [2:0] StInsert = 3'd2;
  localparam logic [2:0] StFull   = 3'd3;
  localparam logic [2:0] StQuery  = 3'd4;

  // packed table row
  typedef struct packed {
    logic [63:0] key;
    logic [47:0] kavg;
    logic [47:0] dev;
    logic [47:0] xavg;
    logic [15:0] nx;
    logic [15:0] nk;
    logic [15:0] nn;
  } entry_t;

  // request to the shared averaging unit
  typedef struct packed {
    logic        start;
    logic        slow;   // 7/8 weighting instead of halving
    logic [47:0] avg;
    logic [47:0] smp;
  } avg_req_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    sat_inc = (c == CntMax) ? c : c + 16'd1;
  endfunction

endpackage

[rtl/kect_avg_unit.sv]
// ----------------------------------------------------------------------------
// kect_avg_unit: shared averaging unit
// one registered step: (a+s)/2 or (7a+s)/8, truncated to 48 bits
// ----------------------------------------------------------------------------
module kect_avg_unit (
  input  logic               clk,
  input  kect_pkg::avg_req_t req,
  output logic [47:0]        res_r
);

  logic [51:0] sum;
  logic [47:0] res_nxt;

  always_comb begin
    if (req.slow) begin
      sum     = {req.avg, 3'b000} - {4'd0, req.avg} + {4'd0, req.smp};
      res_nxt = sum[50:3];
    end else begin
      sum     = {4'd0, req.avg} + {4'd0, req.smp};
      res_nxt = sum[48:1];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      res_r <= res_nxt;
    end
  end

endmodule

[rtl/keyed_ewma_cost_table_top.sv]
// ----------------------------------------------------------------------------
// keyed_ewma_cost_table_top: keyed timing statistics table
// linear key search, then a read-modify-write through one averaging unit
// ----------------------------------------------------------------------------
// search: scan the used cells until the key hits or the used count is reached,
//   then up to four averages run in turn through the one averaging unit
// flow: one item at a time, the next is accepted in the cycle after the
//   result is registered; a result still waiting only holds the final step
// reset: used count, device priors and their counters return to start values;
//   the table memory is not cleared, only cells below the used count are read
module keyed_ewma_cost_table_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[0], cell_key[64:1], device[65], is_resident[66], kernel_time[114:67],
  // transfer_time[162:115], kernel_valid[163], transfer_valid[164], zero fill
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], found[3], kernel_estimate[51:4], transfer_estimate[99:52],
  // deviation[147:100], sample_count[163:148], zero fill
  output logic [167:0] out_tdata
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_WAIT  = 8'b0000_0100,
    S_DEC   = 8'b0000_1000,
    S_KAVG  = 8'b0001_0000,
    S_DAVG  = 8'b0010_0000,
    S_PXAV  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // captured item
  logic        cmd_r, dev_r, res_r, kv_r, xv_r;
  logic [63:0] key_r;
  logic [47:0] kt_r, xt_r;

  kect_pkg::entry_t mem [kect_pkg::Entries];
  kect_pkg::entry_t rd_r, ent_r, ent_nxt;
  logic [kect_pkg::IdxW-1:0]  rd_addr, idx_r;
  logic [kect_pkg::UsedW-1:0] scan_r, used_r;
  logic        hit_r, rd_valid_r;
  logic        scan_hit, note_act, room, apply, done_go;
  logic        wr_en;
  logic [47:0] prior_r [2];
  logic [15:0] pcnt_r [2];
  logic [1:0]  phase_r;  // which average the unit works on
  logic [47:0] kdiff, kdiff_r;
  logic        zero_x;

  kect_pkg::avg_req_t areq;
  logic [47:0]        ares;

  kect_avg_unit u_avg (.clk(clk), .req(areq), .res_r(ares));

  logic         pipe_vld_r;
  logic [167:0] out_r, ans;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = pipe_vld_r;
  assign out_tdata  = out_r;

  assign rd_addr = scan_r[kect_pkg::IdxW-1:0];

  // memory read during scan, and write-back of the working cell when an applied note leaves
  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
    if (wr_en) begin
      mem[idx_r] <= ent_r;
    end
  end

  assign zero_x = res_r && kt_r == 48'd0 && xt_r == 48'd0;

  // distance of the sample from the cell's average before this note
  assign kdiff = (kt_r > ent_r.kavg) ? kt_r - ent_r.kavg : ent_r.kavg - kt_r;

  assign scan_hit = rd_valid_r && !hit_r && (rd_r.key == key_r);
  assign note_act = kv_r || xv_r || zero_x || res_r;
  assign room     = hit_r || (used_r < kect_pkg::UsedW'(kect_pkg::Entries));
  assign apply    = !cmd_r && note_act && room;
  // result leaves once the output register is free or being emptied
  assign done_go  = (state_r == S_DONE) && (!pipe_vld_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    wr_en     = 1'b0;
    areq      = '0;
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_SCAN;
      S_SCAN: if (scan_r >= used_r || scan_hit || hit_r) state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_DEC;
      S_DEC:  state_nxt = (apply && (kv_r || xv_r)) ? S_KAVG : S_DONE;
      S_KAVG: begin
        areq.start = 1'b1;
        case (phase_r)
          2'd0: begin
            areq.slow = ent_r.nk >= 16'd4; areq.avg = ent_r.kavg; areq.smp = kt_r;
          end
          2'd1: begin
            areq.slow = ent_r.nk >= 16'd4; areq.avg = ent_r.dev; areq.smp = kdiff_r;
          end
          2'd2: begin
            areq.slow = pcnt_r[dev_r] >= 16'd4; areq.avg = prior_r[dev_r];
            areq.smp  = kt_r;
          end
          default: begin
            areq.slow = ent_r.nx >= 16'd4; areq.avg = ent_r.xavg; areq.smp = xt_r;
          end
        endcase
        state_nxt = S_DAVG;
      end
      S_DAVG: state_nxt = S_PXAV;
      S_PXAV: begin
        // kernel, deviation and prior when a kernel time came, then transfer when a transfer time came
        if (phase_r == 2'd0 || phase_r == 2'd1 || (phase_r == 2'd2 && xv_r))
          state_nxt = S_KAVG;
        else
          state_nxt = S_DONE;
      end
      S_DONE: if (done_go) begin
        state_nxt = S_IDLE;
        wr_en     = apply;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // working copy of the cell
  always_comb begin
    ent_nxt = ent_r;
    case (state_r)
      S_SCAN: if (scan_hit) ent_nxt = rd_r;
      S_WAIT: if (!hit_r) begin
        ent_nxt      = '0;
        ent_nxt.key  = key_r;
        ent_nxt.kavg = prior_r[dev_r];
      end
      S_DEC: if (apply) begin
        ent_nxt.nn = kect_pkg::sat_inc(ent_r.nn);
        if (!xv_r && zero_x) begin
          ent_nxt.xavg = '0;
          ent_nxt.nx   = kect_pkg::sat_inc(ent_r.nx);
        end
      end
      S_DAVG: begin
        case (phase_r)
          2'd0: ent_nxt.kavg = ares;
          2'd1: ent_nxt.dev  = ares;
          2'd2: ;
          default: begin
            ent_nxt.xavg = ares;
            ent_nxt.nx   = kect_pkg::sat_inc(ent_r.nx);
          end
        endcase
      end
      // kernel count bumps after deviation used it
      S_PXAV: if (phase_r == 2'd1) ent_nxt.nk = kect_pkg::sat_inc(ent_r.nk);
      default: ;
    endcase
  end

  // answer item
  always_comb begin
    ans = '0;
    if (cmd_r) begin
      ans[2:0]  = kect_pkg::StQuery;
      ans[3]    = hit_r;
      ans[51:4] = prior_r[dev_r];
      if (hit_r) begin
        if (ent_r.nk >= 16'd2) ans[51:4] = ent_r.kavg;
        else if (ent_r.nk == 16'd1)
          ans[51:4] = 48'(({1'b0, ent_r.kavg} + {1'b0, prior_r[dev_r]}) >> 1);
        ans[99:52]   = (ent_r.nx != 16'd0) ? ent_r.xavg : 48'd0;
        ans[147:100] = ent_r.dev;
        ans[163:148] = ent_r.nn;
      end
    end else if (!note_act) begin
      ans[2:0] = kect_pkg::StSkip;
    end else if (hit_r) begin
      ans[2:0] = kect_pkg::StUpdate;
      ans[3]   = 1'b1;
    end else if (!room) begin
      ans[2:0] = kect_pkg::StFull;
    end else begin
      ans[2:0] = kect_pkg::StInsert;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (done_go) out_r <= ans;
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        cmd_r <= in_tdata[0];   key_r <= in_tdata[64:1];
        dev_r <= in_tdata[65];  res_r <= in_tdata[66];
        kt_r  <= in_tdata[114:67]; xt_r <= in_tdata[162:115];
        kv_r  <= in_tdata[163]; xv_r <= in_tdata[164];
        scan_r <= '0;
      end
      S_SCAN: begin
        if (scan_hit) idx_r <= kect_pkg::IdxW'(scan_r - 1'b1);
        else if (!hit_r && scan_r < used_r) scan_r <= scan_r + 1'b1;
      end
      S_WAIT: if (!hit_r) idx_r <= used_r[kect_pkg::IdxW-1:0];
      S_DEC: begin
        kdiff_r <= kdiff;
        phase_r <= kv_r ? 2'd0 : 2'd3;
      end
      S_PXAV: phase_r <= phase_r + 2'd1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pipe_vld_r <= 1'b0;
      used_r     <= '0;
      prior_r[0] <= kect_pkg::PriorReset;
      prior_r[1] <= kect_pkg::PriorReset;
      pcnt_r[0]  <= '0;
      pcnt_r[1]  <= '0;
      hit_r      <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done_go) pipe_vld_r <= 1'b1;
      else if (out_tready) pipe_vld_r <= 1'b0;
      if (wr_en && !hit_r) used_r <= used_r + 1'b1;
      if (state_r == S_IDLE && in_tvalid && in_tready) begin
        hit_r      <= 1'b0;
        rd_valid_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        if (scan_hit) hit_r <= 1'b1;
        else if (!hit_r && scan_r < used_r) rd_valid_r <= 1'b1;
      end
      if (state_r == S_DAVG && phase_r == 2'd2) begin
        prior_r[dev_r] <= ares;
        pcnt_r[dev_r]  <= kect_pkg::sat_inc(pcnt_r[dev_r]);
      end
    end
  end

`ifndef SYNTHESIS
  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= kect_pkg::UsedW'(kect_pkg::Entries)) else $error("used count overflow");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("ready while busy");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_tvalid) else $error("no result after item");
  a_avg_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_KAVG |=> state_r == S_DAVG) else $error("averaging step lost");
`endif

endmodule

[dv/keyed_ewma_cost_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_ewma_cost_table_checker: result predictor and scoreboard
// watches both streams, predicts each answer and compares it field by field
// ----------------------------------------------------------------------------
module keyed_ewma_cost_table_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [167:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [167:0] out_tdata,
  output int           fail_count,
  output int           pending,
  output int           status_seen [5]
);

  // highest field first, so status lands in the low bits
  typedef struct packed {
    logic [15:0] cnt;
    logic [47:0] dev;
    logic [47:0] xest;
    logic [47:0] kest;
    logic        found;
    logic [2:0]  status;
  } answer_t;

  kect_pkg::entry_t cells [kect_pkg::Entries];
  int unsigned  cells_used;
  logic [47:0]  prior [2];
  logic [15:0]  prior_n [2];
  answer_t      expected_answers [$];

  function automatic logic [47:0] ewma(logic [47:0] a, logic [15:0] n, logic [47:0] s);
    logic [50:0] w;
    if (n < 16'd4) begin
      w = ({3'd0, a} + s) >> 1;
    end else begin
      w = ({3'd0, a} * 7 + s) >> 3;
    end
    return w[47:0];
  endfunction

  function automatic answer_t predict_answer(logic [167:0] d);
    logic        cmd, dv, res, kv, xv, zx;
    logic [63:0] key;
    logic [47:0] kt, xt, old, diff;
    int          idx;
    answer_t     a;
    cmd = d[0]; key = d[64:1]; dv = d[65]; res = d[66];
    kt = d[114:67]; xt = d[162:115]; kv = d[163]; xv = d[164];
    a = '0;
    idx = -1;
    for (int i = 0; i < cells_used; i++) begin
      if (idx < 0 && cells[i].key == key) idx = i;
    end
    if (cmd) begin
      a.status = kect_pkg::StQuery;
      a.kest = prior[dv];
      if (idx >= 0) begin
        a.found = 1'b1;
        if (cells[idx].nk >= 2) a.kest = cells[idx].kavg;
        else if (cells[idx].nk == 1)
          a.kest = 48'(({1'b0, cells[idx].kavg} + {1'b0, prior[dv]}) >> 1);
        a.xest = (cells[idx].nx != 0) ? cells[idx].xavg : 48'd0;
        a.dev = cells[idx].dev;
        a.cnt = cells[idx].nn;
      end
      return a;
    end
    zx = res && xt == 0 && kt == 0;
    if (!kv && !xv && !zx && !res) begin
      a.status = kect_pkg::StSkip;
      return a;
    end
    if (idx >= 0) begin
      a.status = kect_pkg::StUpdate;
      a.found = 1'b1;
    end else if (cells_used >= kect_pkg::Entries) begin
      a.status = kect_pkg::StFull;
      return a;
    end else begin
      idx = int'(cells_used);
      cells_used++;
      cells[idx] = '0;
      cells[idx].key = key;
      cells[idx].kavg = prior[dv];
      a.status = kect_pkg::StInsert;
    end
    cells[idx].nn = kect_pkg::sat_inc(cells[idx].nn);
    if (kv) begin
      old = cells[idx].kavg;
      diff = (kt > old) ? kt - old : old - kt;
      cells[idx].kavg = ewma(old, cells[idx].nk, kt);
      cells[idx].dev = ewma(cells[idx].dev, cells[idx].nk, diff);
      cells[idx].nk = kect_pkg::sat_inc(cells[idx].nk);
      prior[dv] = ewma(prior[dv], prior_n[dv], kt);
      prior_n[dv] = kect_pkg::sat_inc(prior_n[dv]);
    end
    if (xv) begin
      cells[idx].xavg = ewma(cells[idx].xavg, cells[idx].nx, xt);
      cells[idx].nx = kect_pkg::sat_inc(cells[idx].nx);
    end else if (zx) begin
      cells[idx].xavg = '0;
      cells[idx].nx = kect_pkg::sat_inc(cells[idx].nx);
    end
    return a;
  endfunction

  assign pending = expected_answers.size();

  always @(posedge clk) begin
    answer_t e, g;
    if (!rst_n) begin
      cells_used = 0;
      prior[0] = kect_pkg::PriorReset;
      prior[1] = kect_pkg::PriorReset;
      prior_n[0] = '0;
      prior_n[1] = '0;
      fail_count <= 0;
      for (int s = 0; s < 5; s++) status_seen[s] <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_answers.push_back(predict_answer(in_tdata));
      if (out_tvalid && out_tready) begin
        g = out_tdata[163:0];
        if (expected_answers.size() == 0) begin
          $error("unexpected answer %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_answers.pop_front();
          if (g.status < 5) status_seen[g.status] <= status_seen[g.status] + 1;
          if (g !== e) begin
            fail_count <= fail_count + 1;
            if (g.status !== e.status) $error("status exp %0d got %0d", e.status, g.status);
            if (g.found !== e.found) $error("found exp %0d got %0d", e.found, g.found);
            if (g.kest !== e.kest) $error("kernel_estimate exp %0d got %0d", e.kest, g.kest);
            if (g.xest !== e.xest)
              $error("transfer_estimate exp %0d got %0d", e.xest, g.xest);
            if (g.dev !== e.dev) $error("deviation exp %0d got %0d", e.dev, g.dev);
            if (g.cnt !== e.cnt) $error("sample_count exp %0d got %0d", e.cnt, g.cnt);
          end
        end
      end
    end
  end

endmodule

[dv/keyed_ewma_cost_table_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_ewma_cost_table_top_tb: stimulus and verdict for the cost table
// directed notes and queries, then random traffic over a small key pool with
// bursty sender, stalling receiver and a table-full phase
// ----------------------------------------------------------------------------
module keyed_ewma_cost_table_top_tb;

  localparam logic CmdNote  = 1'b0;
  localparam logic CmdQuery = 1'b1;
  localparam int   LimitCycles = 900000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [167:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  int           fail_count, pending;
  int           status_seen [5];
  int           cycle_count = 0;
  int           items_sent = 0;
  logic [63:0]  key_pool [80];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  keyed_ewma_cost_table_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  keyed_ewma_cost_table_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending), .status_seen(status_seen)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("FAIL keyed_ewma_cost_table_top");
      $finish;
    end
  end

  // receiver stall pattern: long ready stretches mixed with random stalls
  always @(posedge clk) begin
    int phase;
    phase = (cycle_count / 3000) % 3;
    if (!rst_n) out_tready <= 1'b0;
    else if (phase == 0) out_tready <= 1'b1;
    else if (phase == 1) out_tready <= ($urandom_range(0, 3) != 0);
    else out_tready <= ($urandom_range(0, 9) < 3);
  end

  // one item, held until accepted
  task automatic send_item(logic cmd, logic [63:0] key, logic dv, logic res,
                           logic [47:0] kt, logic [47:0] xt, logic kv, logic xv);
    in_tdata  <= {3'b0, xv, kv, xt, kt, res, dv, key, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic idle_cycles(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_time();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {48{1'b1}};
      2: return 48'({$urandom, $urandom});
      default: return 48'($urandom_range(1000, 40000000));
    endcase
  endfunction

  // random note or query over key pool entries [0, span)
  task automatic random_item(int span);
    logic [63:0] k;
    logic        res;
    k = key_pool[$urandom_range(0, span - 1)];
    res = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 2) == 0) begin
      send_item(CmdQuery, k, 1'($urandom_range(0, 1)), res, rand_time(), rand_time(),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if ($urandom_range(0, 9) == 0) begin
      send_item(CmdNote, k, 1'($urandom_range(0, 1)), res, '0, '0,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else begin
      send_item(CmdNote, k, 1'($urandom_range(0, 1)), res, rand_time(), rand_time(),
                $urandom_range(0, 4) != 0, $urandom_range(0, 2) != 0);
    end
  endtask

  initial begin
    for (int i = 0; i < 80; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: absent query, skip, inserts, averaging phases, zero transfer
    send_item(CmdQuery, key_pool[0], 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    send_item(CmdNote, key_pool[0], 1'b0, 1'b0, '1, '1, 1'b0, 1'b0);
    send_item(CmdNote, key_pool[0], 1'b0, 1'b0, '1, '1, 1'b1, 1'b0);
    send_item(CmdQuery, key_pool[0], 1'b1, 1'b0, '0, '0, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++)
      send_item(CmdNote, key_pool[0], 1'b0, 1'b0, 48'd5000 * i, '1, 1'b1, 1'b1);
    send_item(CmdQuery, key_pool[0], 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    send_item(CmdNote, key_pool[1], 1'b1, 1'b1, '0, '0, 1'b0, 1'b0);
    send_item(CmdQuery, key_pool[1], 1'b1, 1'b1, '0, '0, 1'b0, 1'b0);
    send_item(CmdNote, key_pool[1], 1'b1, 1'b1, 48'd7, '0, 1'b0, 1'b0);
    send_item(CmdNote, key_pool[1], 1'b1, 1'b0, 48'd0, '1, 1'b0, 1'b1);
    send_item(CmdQuery, key_pool[1], 1'b0, 1'b1, '1, '1, 1'b1, 1'b1);
    drain();

    // random traffic on a small pool, bursty sender
    while (items_sent < 900) begin
      repeat ($urandom_range(1, 30)) random_item(12);
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 80));
      if ($urandom_range(0, 15) == 0) drain();
    end
    drain();

    // fill the table to overflow, then keep hammering
    for (int i = 2; i < 80; i++)
      send_item(CmdNote, key_pool[i], i[0], 1'b0, rand_time(), rand_time(), 1'b1, 1'b1);
    while (items_sent < 1420) begin
      repeat ($urandom_range(1, 20)) random_item(80);
      idle_cycles($urandom_range(0, 40));
    end
    drain();
    in_tvalid <= 1'b0;
    repeat (200) @(posedge clk);

    $display("covered %0d items: skip %0d update %0d insert %0d full %0d query %0d",
             items_sent, status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4]);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS keyed_ewma_cost_table_top");
    end else begin
      $display("FAIL keyed_ewma_cost_table_top");
    end
    $finish;
  end

endmodule
